[design/ps2sc_pkg.sv]
// ----------------------------------------------------------------------------
// ps2sc_pkg
// shared types, scancode constants and spanish-layout character tables
// ----------------------------------------------------------------------------
package ps2sc_pkg;

    // transaction kinds on the request channel
    localparam logic KIND_SCANCODE = 1'b0;
    localparam logic KIND_READ     = 1'b1;

    // set 1 scancodes of interest
    localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
    localparam logic [6:0] SC_LSHIFT     = 7'h2A;
    localparam logic [6:0] SC_RSHIFT     = 7'h36;
    localparam logic [6:0] SC_CTRL       = 7'h1D;
    localparam logic [6:0] SC_ALT        = 7'h38;
    localparam logic [6:0] SC_CAPS       = 7'h3A;

    // character to push into the queue
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } ps2sc_push_t;

    // result of a read, registered: valid in the cycle after the request
    typedef struct packed {
        logic       empty;
        logic [7:0] ch;
    } ps2sc_rd_t;

    // cp437 codes, unshifted
    localparam logic [7:0] MAP_PLAIN [0:127] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'h00, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hA4,
        8'h00, 8'h00, 8'h00, 8'h87, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h3C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // cp437 codes, shift held
    localparam logic [7:0] MAP_SHIFTED [0:127] = '{
        8'h00, 8'h1B, 8'h21, 8'h22, 8'h00, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h00, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hA5,
        8'h00, 8'h00, 8'h00, 8'h80, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h3E, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage

[design/ps2sc_if.sv]
// ----------------------------------------------------------------------------
// ps2sc request and response channels
// valid/ready channels carrying scancode or read transactions and results
// ----------------------------------------------------------------------------
interface ps2sc_req_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] scancode;

    modport source (output valid, output kind, output scancode, input ready);
    modport sink   (input valid, input kind, input scancode, output ready);
endinterface

interface ps2sc_rsp_if;
    logic       valid;
    logic       ready;
    logic       empty_res;
    logic [7:0] character;

    modport source (output valid, output empty_res, output character, input ready);
    modport sink   (input valid, input empty_res, input character, output ready);
endinterface

[design/ps2_scancode_to_char_fifo.sv]
// ----------------------------------------------------------------------------
// ps2_scancode_to_char_fifo
// ps/2 set 1 scancode decoder (spanish layout) feeding a character queue
// ----------------------------------------------------------------------------
// usage:
//   req channel carries two kinds of transaction. kind 0 delivers one raw
//   set 1 scancode byte; it updates the prefix and shift state and may push
//   one cp437 character into the queue. it gives no response. kind 1 asks
//   for one character and always gives exactly one rsp transaction:
//   empty_res = 1 and character = 0 when the queue held nothing, else the
//   oldest character.
//   throughput is one transaction per cycle while req ready is high. a read
//   result passes the registered ram read stage, then the output register.
//   a character pushed in one cycle can be read in the next.
//   the queue holds FIFO_DEPTH characters; further characters are dropped.
//   reset clears shift, the extended prefix, the pointers and the count; the
//   ram needs no clearing since only counted entries are ever read.
//   when rsp stalls, one read result waits in the output register and one
//   in the ram read stage; req ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module ps2_scancode_to_char_fifo
    import ps2sc_pkg::*;
#(
    parameter int FIFO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    ps2sc_req_if.sink          req,
    ps2sc_rsp_if.source        rsp
);

    ps2sc_push_t push;
    ps2sc_rd_t   rd;

    logic       accept;
    logic       pop_req;
    logic       rd_stage_move;

    // read stage: ram data is valid while this is set
    logic       rd_valid_reg, rd_valid_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic       out_empty_reg;
    logic [7:0] out_char_reg;

    // the read stage moves whenever the output register is free or draining
    assign rd_stage_move = rd_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready     = !rd_valid_reg || !out_valid_reg || rsp.ready;
    assign accept        = req.valid && req.ready;
    assign pop_req       = accept && (req.kind == KIND_READ);

    always_comb
    begin
        rd_valid_next = rd_valid_reg;
        if (rd_stage_move)
        begin
            rd_valid_next = 1'b0;
        end
        if (pop_req)
        begin
            rd_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (rd_stage_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded as the read stage hands over
    always_ff @(posedge clk)
    begin
        if (rd_stage_move)
        begin
            out_empty_reg <= rd.empty;
            out_char_reg  <= rd.ch;
        end
    end

    ps2sc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (accept && (req.kind == KIND_SCANCODE)),
        .scancode (req.scancode),
        .push     (push)
    );

    ps2sc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop_req (pop_req),
        .rd      (rd)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.empty_res = out_empty_reg;
    assign rsp.character = out_char_reg;

endmodule

[design/ps2sc_ram.sv]
// ----------------------------------------------------------------------------
// ps2sc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ps2sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/ps2sc_decode.sv]
// ----------------------------------------------------------------------------
// ps2sc_decode
// tracks prefix and shift state and maps make codes to characters
// ----------------------------------------------------------------------------
module ps2sc_decode
    import ps2sc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [7:0]  scancode,
    output ps2sc_push_t push
);

    logic shift_reg, shift_next;
    logic ext_reg, ext_next;
    logic is_shift_key;
    logic [7:0] ch;

    assign is_shift_key = (scancode[6:0] == SC_LSHIFT) || (scancode[6:0] == SC_RSHIFT);
    assign ch = shift_reg ? MAP_SHIFTED[scancode[6:0]] : MAP_PLAIN[scancode[6:0]];

    always_comb
    begin
        shift_next = shift_reg;
        ext_next   = ext_reg;
        push.valid = 1'b0;
        push.ch    = ch;
        if (en)
        begin
            if (scancode == SC_EXT_PREFIX)
            begin
                ext_next = 1'b1;
            end
            else if (scancode[7])
            begin
                // break: only a plain shift release drops shift
                if (!ext_reg && is_shift_key)
                begin
                    shift_next = 1'b0;
                end
                ext_next = 1'b0;
            end
            else if (ext_reg)
            begin
                ext_next = 1'b0;
            end
            else if (is_shift_key)
            begin
                shift_next = 1'b1;
            end
            else if (!(scancode[6:0] inside {SC_CTRL, SC_ALT, SC_CAPS}))
            begin
                push.valid = (ch != 8'h00);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ext_reg   <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

[design/ps2sc_fifo.sv]
// ----------------------------------------------------------------------------
// ps2sc_fifo
// character queue on a ram, with pointers, fill count and read stage
// ----------------------------------------------------------------------------
module ps2sc_fifo
    import ps2sc_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ps2sc_push_t push,
    input  logic        pop_req,
    output ps2sc_rd_t   rd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             empty_reg;
    logic             do_write;
    logic             do_read;
    logic [7:0]       rdata;

    // drop when full; a pop never coincides with a push
    assign do_write = push.valid && (count_reg != CNT_W'(DEPTH));
    assign do_read  = pop_req && (count_reg != '0);

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_write)
        begin
            wptr_next  = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_read)
        begin
            rptr_next  = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
            if (pop_req)
            begin
                empty_reg <= (count_reg == '0);
            end
        end
    end

    ps2sc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_write),
        .waddr (wptr_reg),
        .wdata (push.ch),
        .re    (do_read),
        .raddr (rptr_reg),
        .rdata (rdata)
    );

    assign rd.empty = empty_reg;
    assign rd.ch    = empty_reg ? 8'h00 : rdata;

endmodule
